### rtl/core/fttc_pkg.sv
package fttc_pkg;

    localparam int MAX_FRAME_DIM = 2048;

    // Raster position counters run up to twice the largest frame dimension.
    localparam int POS_W      = $clog2(2 * MAX_FRAME_DIM);
    localparam int DIM_W      = 12;
    localparam int PCT_W      = 7;
    localparam int AGE_W      = 16;
    localparam int ID_W       = 16;
    localparam int XY_W       = 11;
    localparam int CNT_W      = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Squared distance of two 11-bit points fits 23 bits; the root unit eats two bits a step.
    localparam int SQ_W       = 2 * XY_W + 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int RAD_W      = ROOT_W;
    localparam int EDGE_W     = XY_W + 2;
    localparam int BND_W      = EDGE_W + 1;
    localparam int PROD_W     = CNT_W + PCT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [POS_W-1:0] ROW_MAX    = POS_W'(2 * MAX_FRAME_DIM - 1);
    localparam logic [RAD_W-1:0] RADIUS_PAD = RAD_W'(7);
    localparam logic [PCT_W-1:0] PCT_SCALE  = PCT_W'(100);
    localparam logic [ID_W-1:0]  ID_NONE    = '1;

    localparam logic CMD_TIP   = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_PCT    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_PCT    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_AGE      = CFG_IDX_W'(4);

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
    localparam logic [PCT_W-1:0] TOUCH_PCT_RST    = PCT_W'(20);
    localparam logic [PCT_W-1:0] HOVER_PCT_RST    = PCT_W'(30);
    localparam logic [AGE_W-1:0] MIN_AGE_RST      = AGE_W'(5);

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_HOVER = 2'd1,
        ACT_TOUCH = 2'd2
    } t_action;

    typedef enum logic [5:0] {
        ST_RUN     = 6'b000001,
        ST_SQUARE  = 6'b000010,
        ST_SUM     = 6'b000100,
        ST_ROOT    = 6'b001000,
        ST_PRODUCT = 6'b010000,
        ST_FINISH  = 6'b100000
    } t_back_state;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [PCT_W-1:0] touch_pct;
        logic [PCT_W-1:0] hover_pct;
        logic [AGE_W-1:0] min_age;
    } t_cfg;

    typedef struct packed {
        logic             load;
        logic [AGE_W-1:0] value;
    } t_age_load;

    typedef struct packed {
        logic             is_pixel;
        logic [ID_W-1:0]  tip_id;
        logic [AGE_W-1:0] tip_age;
        logic [XY_W-1:0]  tip_x;
        logic [XY_W-1:0]  tip_y;
        logic [XY_W-1:0]  cent_x;
        logic [XY_W-1:0]  cent_y;
        logic [XY_W-1:0]  dx_abs;
        logic [XY_W-1:0]  dy_abs;
        logic             shadow_bit;
        logic             fore_bit;
        logic             frame_end;
    } t_op;

    typedef struct packed {
        logic  valid;
        t_op   op;
    } t_op_link;

    typedef struct packed {
        t_action          action;
        logic [XY_W-1:0]  point_x;
        logic [XY_W-1:0]  point_y;
        logic [CNT_W-1:0] shadow_total;
        logic [CNT_W-1:0] fore_total;
    } t_result;

endpackage

### rtl/core/fingertip_touch_classifier_core.sv
// Fingertip touch classifier. Words enter through a four-word queue: fingertip
// words first, then one pixel word per mask pixel in raster order, the last
// with frame_end set, which yields one result word with touch, hover or none.
// Pixel words are handled at one per clock while the back end is in its run
// state. A fingertip word that becomes the chosen tip holds the back end for
// squaring, a 12-step integer square root for the region radius, then the
// region edges; one that is not chosen is popped in the run state. A frame-end
// word holds it for the products and the exact ratio compare, longer while the
// previous result is not popped. The block needs no clearing pass after reset.
// Configuration writes are taken at any clock edge with i_cfg_we high and must
// only be issued while no word is in flight.
module fingertip_touch_classifier_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_cmd,
    input  logic [fttc_pkg::ID_W-1:0]        i_tip_id,
    input  logic [fttc_pkg::AGE_W-1:0]       i_tip_age,
    input  logic [fttc_pkg::XY_W-1:0]        i_tip_x,
    input  logic [fttc_pkg::XY_W-1:0]        i_tip_y,
    input  logic [fttc_pkg::XY_W-1:0]        i_centroid_x,
    input  logic [fttc_pkg::XY_W-1:0]        i_centroid_y,
    input  logic                             i_shadow_bit,
    input  logic                             i_fore_bit,
    input  logic                             i_frame_end,
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       o_action,
    output logic [fttc_pkg::XY_W-1:0]        o_point_x,
    output logic [fttc_pkg::XY_W-1:0]        o_point_y,
    output logic [fttc_pkg::CNT_W-1:0]       o_shadow_total,
    output logic [fttc_pkg::CNT_W-1:0]       o_fore_total,
    input  logic                             i_cfg_we,
    input  logic [fttc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fttc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    fttc_pkg::t_cfg       r_cfg, n_cfg;
    fttc_pkg::t_age_load  w_age_load;
    fttc_pkg::t_op_link   w_link;
    fttc_pkg::t_result    w_res;
    logic                 w_op_pop;
    logic                 w_res_valid;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                fttc_pkg::REG_FRAME_WIDTH:  n_cfg.frame_width  = i_cfg_data[fttc_pkg::DIM_W-1:0];
                fttc_pkg::REG_FRAME_HEIGHT: n_cfg.frame_height = i_cfg_data[fttc_pkg::DIM_W-1:0];
                fttc_pkg::REG_TOUCH_PCT:    n_cfg.touch_pct    = i_cfg_data[fttc_pkg::PCT_W-1:0];
                fttc_pkg::REG_HOVER_PCT:    n_cfg.hover_pct    = i_cfg_data[fttc_pkg::PCT_W-1:0];
                fttc_pkg::REG_MIN_AGE:      n_cfg.min_age      = i_cfg_data[fttc_pkg::AGE_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= fttc_pkg::FRAME_WIDTH_RST;
            r_cfg.frame_height <= fttc_pkg::FRAME_HEIGHT_RST;
            r_cfg.touch_pct    <= fttc_pkg::TOUCH_PCT_RST;
            r_cfg.hover_pct    <= fttc_pkg::HOVER_PCT_RST;
            r_cfg.min_age      <= fttc_pkg::MIN_AGE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // A new minimum age also restarts the age search when no tip is chosen yet.
    assign w_age_load.load  = i_cfg_we && (i_cfg_index == fttc_pkg::REG_MIN_AGE);
    assign w_age_load.value = i_cfg_data[fttc_pkg::AGE_W-1:0];

    fttc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_tip_id     (i_tip_id),
        .i_tip_age    (i_tip_age),
        .i_tip_x      (i_tip_x),
        .i_tip_y      (i_tip_y),
        .i_centroid_x (i_centroid_x),
        .i_centroid_y (i_centroid_y),
        .i_shadow_bit (i_shadow_bit),
        .i_fore_bit   (i_fore_bit),
        .i_frame_end  (i_frame_end),
        .o_link       (w_link),
        .i_pop        (w_op_pop)
    );

    fttc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_age_load  (w_age_load),
        .i_link      (w_link),
        .o_pop       (w_op_pop),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_pop   (pop)
    );

    assign empty          = !w_res_valid;
    assign o_action       = w_res.action;
    assign o_point_x      = w_res.point_x;
    assign o_point_y      = w_res.point_y;
    assign o_shadow_total = w_res.shadow_total;
    assign o_fore_total   = w_res.fore_total;

endmodule

### rtl/core/fttc_isqrt.sv
module fttc_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fttc_pkg::SQ_W-1:0]  i_operand,
    output logic                       o_done,
    output logic [fttc_pkg::ROOT_W-1:0] o_root
);

    localparam int STEPS  = fttc_pkg::SQ_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);
    localparam int REM_W  = fttc_pkg::ROOT_W + 2;

    logic [fttc_pkg::SQ_W-1:0]   r_opnd, n_opnd;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [fttc_pkg::ROOT_W-1:0] r_root, n_root;
    logic [STEP_W-1:0]           r_steps, n_steps;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    logic [REM_W+1:0] w_rem_sh;
    logic [REM_W+1:0] w_trial;

    // One result bit per step: bring down two operand bits, try 4*root+1.
    assign w_rem_sh = {r_rem, r_opnd[fttc_pkg::SQ_W-1 -: 2]};
    assign w_trial  = (REM_W+2)'({r_root, 2'b01});

    always_comb begin
        n_opnd  = r_opnd;
        n_rem   = r_rem;
        n_root  = r_root;
        n_steps = r_steps;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_opnd  = i_operand;
            n_rem   = '0;
            n_root  = '0;
            n_steps = STEP_W'(STEPS);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_opnd  = {r_opnd[fttc_pkg::SQ_W-3:0], 2'b00};
            n_steps = r_steps - STEP_W'(1);
            if (w_rem_sh >= w_trial) begin
                n_rem  = REM_W'(w_rem_sh - w_trial);
                n_root = {r_root[fttc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(w_rem_sh);
                n_root = {r_root[fttc_pkg::ROOT_W-2:0], 1'b0};
            end
            if (r_steps == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_steps <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opnd <= n_opnd;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/core/fttc_front.sv
module fttc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_cmd,
    input  logic [fttc_pkg::ID_W-1:0]   i_tip_id,
    input  logic [fttc_pkg::AGE_W-1:0]  i_tip_age,
    input  logic [fttc_pkg::XY_W-1:0]   i_tip_x,
    input  logic [fttc_pkg::XY_W-1:0]   i_tip_y,
    input  logic [fttc_pkg::XY_W-1:0]   i_centroid_x,
    input  logic [fttc_pkg::XY_W-1:0]   i_centroid_y,
    input  logic                        i_shadow_bit,
    input  logic                        i_fore_bit,
    input  logic                        i_frame_end,
    output fttc_pkg::t_op_link          o_link,
    input  logic                        i_pop
);

    fttc_pkg::t_op                    r_mem [fttc_pkg::QUEUE_DEPTH];
    logic [fttc_pkg::QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [fttc_pkg::QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [fttc_pkg::QPTR_W:0]        r_count, n_count;

    fttc_pkg::t_op w_op;
    logic          w_accept;
    logic          w_take;

    // Sort the word by kind and have the distance magnitudes ready for the squarers.
    always_comb begin
        w_op            = '0;
        w_op.is_pixel   = (i_cmd == fttc_pkg::CMD_PIXEL);
        w_op.tip_id     = i_tip_id;
        w_op.tip_age    = i_tip_age;
        w_op.tip_x      = i_tip_x;
        w_op.tip_y      = i_tip_y;
        w_op.cent_x     = i_centroid_x;
        w_op.cent_y     = i_centroid_y;
        w_op.dx_abs     = (i_centroid_x >= i_tip_x) ? i_centroid_x - i_tip_x
                                                    : i_tip_x - i_centroid_x;
        w_op.dy_abs     = (i_centroid_y >= i_tip_y) ? i_centroid_y - i_tip_y
                                                    : i_tip_y - i_centroid_y;
        w_op.shadow_bit = i_shadow_bit;
        w_op.fore_bit   = i_fore_bit;
        w_op.frame_end  = i_frame_end;
    end

    assign o_full   = (r_count == (fttc_pkg::QPTR_W+1)'(fttc_pkg::QUEUE_DEPTH));
    assign w_accept = i_push && !o_full;
    assign w_take   = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = w_accept ? r_wr_ptr + fttc_pkg::QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_take ? r_rd_ptr + fttc_pkg::QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_accept && !w_take) begin
            n_count = r_count + (fttc_pkg::QPTR_W+1)'(1);
        end else if (!w_accept && w_take) begin
            n_count = r_count - (fttc_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wr_ptr] <= w_op;
        end
    end

    assign o_link.valid = (r_count != '0);
    assign o_link.op    = r_mem[r_rd_ptr];

endmodule

### rtl/core/fttc_back.sv
module fttc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fttc_pkg::t_cfg        i_cfg,
    input  fttc_pkg::t_age_load   i_age_load,
    input  fttc_pkg::t_op_link    i_link,
    output logic                  o_pop,
    output fttc_pkg::t_result     o_res,
    output logic                  o_res_valid,
    input  logic                  i_res_pop
);

    fttc_pkg::t_back_state r_state, n_state;

    logic [fttc_pkg::ID_W-1:0]      r_remembered_id, n_remembered_id;
    logic [fttc_pkg::ID_W-1:0]      r_chosen_id, n_chosen_id;
    logic                           r_choice_valid, n_choice_valid;
    logic                           r_locked, n_locked;
    logic [fttc_pkg::AGE_W-1:0]     r_best_age, n_best_age;
    logic [fttc_pkg::XY_W-1:0]      r_tip_x, n_tip_x;
    logic [fttc_pkg::XY_W-1:0]      r_tip_y, n_tip_y;
    logic [fttc_pkg::XY_W-1:0]      r_cent_x, n_cent_x;
    logic [fttc_pkg::XY_W-1:0]      r_cent_y, n_cent_y;
    logic [fttc_pkg::XY_W-1:0]      r_dx, n_dx;
    logic [fttc_pkg::XY_W-1:0]      r_dy, n_dy;
    logic [2*fttc_pkg::XY_W-1:0]    r_sq_x, n_sq_x;
    logic [2*fttc_pkg::XY_W-1:0]    r_sq_y, n_sq_y;
    logic [fttc_pkg::XY_W-1:0]      r_left, n_left;
    logic [fttc_pkg::XY_W-1:0]      r_top, n_top;
    logic [fttc_pkg::EDGE_W-1:0]    r_right, n_right;
    logic [fttc_pkg::EDGE_W-1:0]    r_bottom, n_bottom;
    logic [fttc_pkg::POS_W-1:0]     r_col, n_col;
    logic [fttc_pkg::POS_W-1:0]     r_row, n_row;
    logic [fttc_pkg::CNT_W-1:0]     r_shadow, n_shadow;
    logic [fttc_pkg::CNT_W-1:0]     r_fore, n_fore;
    logic [fttc_pkg::PROD_W-1:0]    r_s100, n_s100;
    logic [fttc_pkg::PROD_W-1:0]    r_tf, n_tf;
    logic [fttc_pkg::PROD_W-1:0]    r_hf, n_hf;
    fttc_pkg::t_result              r_res, n_res;
    logic                           r_res_valid, n_res_valid;

    logic                           w_root_start;
    logic [fttc_pkg::SQ_W-1:0]      w_sq_sum;
    logic                           w_root_done;
    logic [fttc_pkg::ROOT_W-1:0]    w_root;
    logic [fttc_pkg::RAD_W-1:0]     w_radius;
    logic signed [fttc_pkg::BND_W-1:0] w_left_d, w_top_d;
    logic signed [fttc_pkg::BND_W-1:0] w_lim_x, w_lim_y, w_hx, w_hy;
    logic signed [fttc_pkg::BND_W-1:0] w_col_s, w_row_s;
    logic signed [fttc_pkg::BND_W-1:0] w_right_s, w_bottom_s;
    logic                           w_in_region;
    logic [fttc_pkg::POS_W:0]       w_col_inc;
    logic                           w_take;
    fttc_pkg::t_action              w_action;

    assign w_sq_sum = fttc_pkg::SQ_W'(r_sq_x) + fttc_pkg::SQ_W'(r_sq_y);

    fttc_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_root_start),
        .i_operand (w_sq_sum),
        .o_done    (w_root_done),
        .o_root    (w_root)
    );

    assign w_radius = w_root + fttc_pkg::RADIUS_PAD;
    assign w_left_d = $signed(fttc_pkg::BND_W'(r_cent_x)) - $signed(fttc_pkg::BND_W'(w_radius));
    assign w_top_d  = $signed(fttc_pkg::BND_W'(r_cent_y)) - $signed(fttc_pkg::BND_W'(w_radius));

    // The upper edge is clipped to two short of the frame size, which may go negative.
    assign w_lim_x    = $signed(fttc_pkg::BND_W'(i_cfg.frame_width))
                        - $signed(fttc_pkg::BND_W'(2));
    assign w_lim_y    = $signed(fttc_pkg::BND_W'(i_cfg.frame_height))
                        - $signed(fttc_pkg::BND_W'(2));
    assign w_right_s  = $signed(fttc_pkg::BND_W'(r_right));
    assign w_bottom_s = $signed(fttc_pkg::BND_W'(r_bottom));
    assign w_hx       = (w_right_s < w_lim_x) ? w_right_s : w_lim_x;
    assign w_hy       = (w_bottom_s < w_lim_y) ? w_bottom_s : w_lim_y;
    assign w_col_s    = $signed(fttc_pkg::BND_W'(r_col));
    assign w_row_s    = $signed(fttc_pkg::BND_W'(r_row));

    assign w_in_region = r_choice_valid
                         && (w_col_s >= $signed(fttc_pkg::BND_W'(r_left))) && (w_col_s < w_hx)
                         && (w_row_s >= $signed(fttc_pkg::BND_W'(r_top))) && (w_row_s < w_hy);

    assign w_col_inc = (fttc_pkg::POS_W+1)'(r_col) + (fttc_pkg::POS_W+1)'(1);

    always_comb begin
        w_action = fttc_pkg::ACT_NONE;
        if (r_choice_valid && (r_fore != '0)) begin
            if (r_s100 <= r_tf) begin
                w_action = fttc_pkg::ACT_TOUCH;
            end else if (r_s100 <= r_hf) begin
                w_action = fttc_pkg::ACT_HOVER;
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_remembered_id = r_remembered_id;
        n_chosen_id     = r_chosen_id;
        n_choice_valid  = r_choice_valid;
        n_locked        = r_locked;
        n_best_age      = r_best_age;
        n_tip_x         = r_tip_x;
        n_tip_y         = r_tip_y;
        n_cent_x        = r_cent_x;
        n_cent_y        = r_cent_y;
        n_dx            = r_dx;
        n_dy            = r_dy;
        n_sq_x          = r_sq_x;
        n_sq_y          = r_sq_y;
        n_left          = r_left;
        n_top           = r_top;
        n_right         = r_right;
        n_bottom        = r_bottom;
        n_col           = r_col;
        n_row           = r_row;
        n_shadow        = r_shadow;
        n_fore          = r_fore;
        n_s100          = r_s100;
        n_tf            = r_tf;
        n_hf            = r_hf;
        n_res           = r_res;
        n_res_valid     = r_res_valid;
        o_pop           = 1'b0;
        w_root_start    = 1'b0;
        w_take          = 1'b0;

        if (r_res_valid && i_res_pop) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state)
            fttc_pkg::ST_RUN: begin
                if (i_link.valid) begin
                    o_pop = 1'b1;
                    if (i_link.op.is_pixel) begin
                        if (w_in_region) begin
                            if (i_link.op.shadow_bit && (r_shadow != fttc_pkg::COUNT_MAX)) begin
                                n_shadow = r_shadow + fttc_pkg::CNT_W'(1);
                            end
                            if (i_link.op.fore_bit && (r_fore != fttc_pkg::COUNT_MAX)) begin
                                n_fore = r_fore + fttc_pkg::CNT_W'(1);
                            end
                        end
                        if (w_col_inc >= (fttc_pkg::POS_W+1)'(i_cfg.frame_width)) begin
                            n_col = '0;
                            if (r_row != fttc_pkg::ROW_MAX) begin
                                n_row = r_row + fttc_pkg::POS_W'(1);
                            end
                        end else begin
                            n_col = w_col_inc[fttc_pkg::POS_W-1:0];
                        end
                        if (i_link.op.frame_end) begin
                            n_state = fttc_pkg::ST_PRODUCT;
                        end
                    end else if (!r_locked) begin
                        // The tip chosen last frame wins outright and locks the search.
                        if (i_link.op.tip_id == r_remembered_id) begin
                            w_take   = 1'b1;
                            n_locked = 1'b1;
                        end else if (i_link.op.tip_age >= r_best_age) begin
                            w_take     = 1'b1;
                            n_best_age = i_link.op.tip_age;
                        end
                        if (w_take) begin
                            n_choice_valid = 1'b1;
                            n_chosen_id    = i_link.op.tip_id;
                            n_tip_x        = i_link.op.tip_x;
                            n_tip_y        = i_link.op.tip_y;
                            n_cent_x       = i_link.op.cent_x;
                            n_cent_y       = i_link.op.cent_y;
                            n_dx           = i_link.op.dx_abs;
                            n_dy           = i_link.op.dy_abs;
                            n_state        = fttc_pkg::ST_SQUARE;
                        end
                    end
                end
            end
            fttc_pkg::ST_SQUARE: begin
                n_sq_x  = r_dx * r_dx;
                n_sq_y  = r_dy * r_dy;
                n_state = fttc_pkg::ST_SUM;
            end
            fttc_pkg::ST_SUM: begin
                w_root_start = 1'b1;
                n_state      = fttc_pkg::ST_ROOT;
            end
            fttc_pkg::ST_ROOT: begin
                if (w_root_done) begin
                    n_left   = w_left_d[fttc_pkg::BND_W-1] ? '0 : w_left_d[fttc_pkg::XY_W-1:0];
                    n_top    = w_top_d[fttc_pkg::BND_W-1] ? '0 : w_top_d[fttc_pkg::XY_W-1:0];
                    n_right  = fttc_pkg::EDGE_W'(r_cent_x) + fttc_pkg::EDGE_W'(w_radius);
                    n_bottom = fttc_pkg::EDGE_W'(r_cent_y) + fttc_pkg::EDGE_W'(w_radius);
                    n_state  = fttc_pkg::ST_RUN;
                end
            end
            fttc_pkg::ST_PRODUCT: begin
                n_s100  = fttc_pkg::PROD_W'(r_shadow) * fttc_pkg::PROD_W'(fttc_pkg::PCT_SCALE);
                n_tf    = fttc_pkg::PROD_W'(r_fore) * fttc_pkg::PROD_W'(i_cfg.touch_pct);
                n_hf    = fttc_pkg::PROD_W'(r_fore) * fttc_pkg::PROD_W'(i_cfg.hover_pct);
                n_state = fttc_pkg::ST_FINISH;
            end
            fttc_pkg::ST_FINISH: begin
                if (!r_res_valid || i_res_pop) begin
                    n_res.action       = w_action;
                    n_res.point_x      = (w_action != fttc_pkg::ACT_NONE) ? r_tip_x : '0;
                    n_res.point_y      = (w_action != fttc_pkg::ACT_NONE) ? r_tip_y : '0;
                    n_res.shadow_total = r_shadow;
                    n_res.fore_total   = r_fore;
                    n_res_valid        = 1'b1;
                    if (r_choice_valid) begin
                        n_remembered_id = r_chosen_id;
                    end
                    n_choice_valid = 1'b0;
                    n_locked       = 1'b0;
                    n_best_age     = i_cfg.min_age;
                    n_col          = '0;
                    n_row          = '0;
                    n_shadow       = '0;
                    n_fore         = '0;
                    n_state        = fttc_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = fttc_pkg::ST_RUN;
            end
        endcase

        if (i_age_load.load && !r_choice_valid) begin
            n_best_age = i_age_load.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= fttc_pkg::ST_RUN;
            r_remembered_id <= fttc_pkg::ID_NONE;
            r_chosen_id     <= fttc_pkg::ID_NONE;
            r_choice_valid  <= 1'b0;
            r_locked        <= 1'b0;
            r_best_age      <= fttc_pkg::MIN_AGE_RST;
            r_col           <= '0;
            r_row           <= '0;
            r_shadow        <= '0;
            r_fore          <= '0;
            r_res_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_remembered_id <= n_remembered_id;
            r_chosen_id     <= n_chosen_id;
            r_choice_valid  <= n_choice_valid;
            r_locked        <= n_locked;
            r_best_age      <= n_best_age;
            r_col           <= n_col;
            r_row           <= n_row;
            r_shadow        <= n_shadow;
            r_fore          <= n_fore;
            r_res_valid     <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tip_x  <= n_tip_x;
        r_tip_y  <= n_tip_y;
        r_cent_x <= n_cent_x;
        r_cent_y <= n_cent_y;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_sq_x   <= n_sq_x;
        r_sq_y   <= n_sq_y;
        r_left   <= n_left;
        r_top    <= n_top;
        r_right  <= n_right;
        r_bottom <= n_bottom;
        r_s100   <= n_s100;
        r_tf     <= n_tf;
        r_hf     <= n_hf;
        r_res    <= n_res;
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

### rtl/core/fttc_checker.sv
module fttc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [1:0]                  o_action,
    input  logic [fttc_pkg::XY_W-1:0]   o_point_x,
    input  logic [fttc_pkg::XY_W-1:0]   o_point_y,
    input  logic [fttc_pkg::CNT_W-1:0]  o_shadow_total,
    input  logic [fttc_pkg::CNT_W-1:0]  o_fore_total
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_action) && $stable(o_point_x)
            && $stable(o_point_y) && $stable(o_shadow_total) && $stable(o_fore_total))
        else $error("waiting result word changed before it was popped");

    a_none_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_action == fttc_pkg::ACT_NONE) |-> (o_point_x == '0) && (o_point_y == '0))
        else $error("result with no action carries a point");

    a_action_needs_fore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_action == fttc_pkg::ACT_TOUCH || o_action == fttc_pkg::ACT_HOVER)
            |-> (o_fore_total != '0))
        else $error("touch or hover reported with no foreground pixels");

endmodule

bind fingertip_touch_classifier_core fttc_checker u_fttc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_action       (o_action),
    .o_point_x      (o_point_x),
    .o_point_y      (o_point_y),
    .o_shadow_total (o_shadow_total),
    .o_fore_total   (o_fore_total)
);
